>>> hw/rtl/stok_pkg.sv
package stok_pkg;

  // Result kinds.
  localparam logic [4:0] KIND_EOF    = 5'd0;
  localparam logic [4:0] KIND_IDENT  = 5'd1;
  localparam logic [4:0] KIND_INT    = 5'd2;
  localparam logic [4:0] KIND_STRING = 5'd3;
  localparam logic [4:0] KIND_KW0    = 5'd4;
  localparam logic [4:0] KIND_STAR   = 5'd12;
  localparam logic [4:0] KIND_LPAREN = 5'd13;
  localparam logic [4:0] KIND_RPAREN = 5'd14;
  localparam logic [4:0] KIND_LBRACE = 5'd15;
  localparam logic [4:0] KIND_RBRACE = 5'd16;
  localparam logic [4:0] KIND_SEMI   = 5'd17;
  localparam logic [4:0] KIND_MINUS  = 5'd18;
  localparam logic [4:0] KIND_PLUS   = 5'd19;
  localparam logic [4:0] KIND_ASSIGN = 5'd20;
  localparam logic [4:0] KIND_EQ     = 5'd21;
  localparam logic [4:0] KIND_NE     = 5'd22;
  localparam logic [4:0] KIND_LT     = 5'd23;
  localparam logic [4:0] KIND_LE     = 5'd24;
  localparam logic [4:0] KIND_GT     = 5'd25;
  localparam logic [4:0] KIND_GE     = 5'd26;
  localparam logic [4:0] KIND_COMMA  = 5'd27;

  // Error codes.
  localparam logic [3:0] ERR_NONE         = 4'd0;
  localparam logic [3:0] ERR_OPEN_COMMENT = 4'd1;
  localparam logic [3:0] ERR_LONG_IDENT   = 4'd2;
  localparam logic [3:0] ERR_BAD_INT      = 4'd3;
  localparam logic [3:0] ERR_BAD_ESCAPE   = 4'd4;
  localparam logic [3:0] ERR_NONPRINT     = 4'd5;
  localparam logic [3:0] ERR_OPEN_STRING  = 4'd6;
  localparam logic [3:0] ERR_LONG_STRING  = 4'd7;
  localparam logic [3:0] ERR_BAD_CHAR     = 4'd8;
  localparam logic [3:0] ERR_TOKEN_LIMIT  = 4'd9;

  localparam int MaxIdentBytes  = 63;
  localparam int MaxStringBytes = 255;
  localparam int PositionBits   = 24;
  localparam int QueueDepth     = 4;

  localparam logic [23:0] CAP_RESET = 24'd4096;
  localparam logic [15:0] LEN_MAX   = 16'hFFFF;

  localparam int NumKw = 8;

  // Keyword spellings, zero padded.
  localparam logic [7:0] KW_TEXT [NumKw][16] = '{
    '{"i","n","t",8'h0,8'h0,8'h0,8'h0,8'h0,8'h0,8'h0,8'h0,8'h0,8'h0,8'h0,8'h0,8'h0},
    '{"g","x","_","m","a","i","n",8'h0,8'h0,8'h0,8'h0,8'h0,8'h0,8'h0,8'h0,8'h0},
    '{"g","x","_","a","p","p","_","c","o","n","t","e","x","t",8'h0,8'h0},
    '{"v","o","i","d",8'h0,8'h0,8'h0,8'h0,8'h0,8'h0,8'h0,8'h0,8'h0,8'h0,8'h0,8'h0},
    '{"r","e","t","u","r","n",8'h0,8'h0,8'h0,8'h0,8'h0,8'h0,8'h0,8'h0,8'h0,8'h0},
    '{"l","o","g",8'h0,8'h0,8'h0,8'h0,8'h0,8'h0,8'h0,8'h0,8'h0,8'h0,8'h0,8'h0,8'h0},
    '{"i","f",8'h0,8'h0,8'h0,8'h0,8'h0,8'h0,8'h0,8'h0,8'h0,8'h0,8'h0,8'h0,8'h0,8'h0},
    '{"e","l","s","e",8'h0,8'h0,8'h0,8'h0,8'h0,8'h0,8'h0,8'h0,8'h0,8'h0,8'h0,8'h0}
  };
  localparam logic [4:0] KW_LEN [NumKw] = '{5'd3, 5'd7, 5'd14, 5'd4, 5'd6, 5'd3, 5'd2, 5'd4};

  typedef enum logic [3:0] {
    LX_IDLE, LX_SLASH, LX_LINE, LX_BLOCK, LX_BLOCK_STAR, LX_IDENT, LX_NUMBER,
    LX_STRING, LX_STRING_ESC, LX_OP, LX_DONE
  } lex_mode_e;

  typedef struct packed {
    logic [7:0] char_byte;
    logic       end_of_source;
  } in_item_t;

  typedef struct packed {
    logic [4:0]  token_kind;
    logic [23:0] start_offset;
    logic [23:0] line_number;
    logic [23:0] column_number;
    logic [15:0] token_length;
    logic [3:0]  error_code;
    logic        last_result;
  } out_item_t;

  // A byte with its character class, as the front hands it to the back.
  typedef struct packed {
    logic [7:0] char_byte;
    logic       end_of_source;
    logic       is_space;
    logic       is_alpha;
    logic       is_numeral;
  } cls_item_t;

  // Bit k stays set when keyword k has byte c at position len.
  function automatic logic [NumKw-1:0] kw_keep(logic [15:0] len, logic [7:0] c);
    logic [NumKw-1:0] keep;
    for (int k = 0; k < NumKw; k++) begin
      keep[k] = (len < {11'd0, KW_LEN[k]}) && (KW_TEXT[k][len[3:0]] == c);
    end
    return keep;
  endfunction

endpackage

>>> hw/rtl/stok_fifo.sv
module stok_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      we0_i,
  input  logic [WIDTH-1:0]          wd0_i,
  input  logic                      we1_i,
  input  logic [WIDTH-1:0]          wd1_i,
  input  logic                      re_i,
  output logic [WIDTH-1:0]          rd_o,
  output logic                      empty_o,
  output logic [$clog2(DEPTH):0]    free_o
);
  localparam int AW = $clog2(DEPTH);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0]    wptr_q, rptr_q;
  logic [AW:0]      cnt_q;
  logic [AW-1:0]    wptr1;

  assign wptr1   = wptr_q + AW'(1);
  assign rd_o    = mem_q[rptr_q];
  assign empty_o = (cnt_q == '0);
  assign free_o  = (AW+1)'(DEPTH) - cnt_q;

  always_ff @(posedge clk_i) begin
    if (we0_i) begin
      mem_q[wptr_q] <= wd0_i;
    end
    if (we1_i) begin
      mem_q[wptr1] <= wd1_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_q + AW'(we0_i) + AW'(we1_i);
      rptr_q <= rptr_q + AW'(re_i);
      cnt_q  <= cnt_q + (AW+1)'(we0_i) + (AW+1)'(we1_i) - (AW+1)'(re_i);
    end
  end

`ifndef NO_ASSERTIONS
  a_second_write_pairs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    we1_i |-> we0_i) else $error("second write without first");
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q + (AW+1)'(we0_i) + (AW+1)'(we1_i) - (AW+1)'(re_i)) <= (AW+1)'(DEPTH))
    else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    re_i |-> !empty_o) else $error("queue underflow");
`endif
endmodule

>>> hw/rtl/stok_front.sv
module stok_front #(
  parameter int DEPTH = stok_pkg::QueueDepth
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push,
  output logic                 full,
  input  stok_pkg::in_item_t   item_i,
  output stok_pkg::cls_item_t  cls_o,
  output logic                 cls_empty_o,
  input  logic                 cls_pop_i
);
  import stok_pkg::*;

  cls_item_t            cls;
  logic [7:0]           c;
  logic [$clog2(DEPTH):0] free;
  logic                 take;

  assign c = item_i.char_byte;

  // Character classes are settled here so the back sees flags, not compares.
  always_comb begin
    cls.char_byte     = c;
    cls.end_of_source = item_i.end_of_source;
    cls.is_space      = (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
    cls.is_alpha      = (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || (c == "_");
    cls.is_numeral    = (c >= "0" && c <= "9");
  end

  assign full = (free == '0);
  assign take = push && !full;

  stok_fifo #(.WIDTH($bits(cls_item_t)), .DEPTH(DEPTH)) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we0_i   (take),
    .wd0_i   (cls),
    .we1_i   (1'b0),
    .wd1_i   (cls),
    .re_i    (cls_pop_i),
    .rd_o    (cls_o),
    .empty_o (cls_empty_o),
    .free_o  (free)
  );
endmodule

>>> hw/rtl/stok_back.sv
module stok_back #(
  parameter int MAX_IDENT_BYTES  = stok_pkg::MaxIdentBytes,
  parameter int MAX_STRING_BYTES = stok_pkg::MaxStringBytes,
  parameter int POSITION_BITS    = stok_pkg::PositionBits
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [23:0]          cfg_wdata_i,
  input  stok_pkg::cls_item_t  cls_i,
  input  logic                 cls_valid_i,
  output logic                 cls_pop_o,
  input  logic                 room_i,
  output logic                 res0_we_o,
  output stok_pkg::out_item_t  res0_o,
  output logic                 res1_we_o,
  output stok_pkg::out_item_t  res1_o
);
  import stok_pkg::*;

  localparam int PB = POSITION_BITS;
  localparam logic [15:0] STR_LIMIT = 16'(2 * MAX_STRING_BYTES + 2);
  localparam logic [15:0] IDENT_LIMIT = 16'(MAX_IDENT_BYTES);

  typedef enum logic [1:0] {AF_NONE, AF_IDLE, AF_DISPATCH, AF_EOF} after_e;

  lex_mode_e      mode_q, mode_d;
  logic [7:0]     pend_q, pend_d;
  logic [PB-1:0]  off_q, off_d, line_q, line_d, col_q, col_d;
  logic           after_cr_q, after_cr_d;
  logic [PB-1:0]  ts_off_q, ts_off_d, ts_line_q, ts_line_d, ts_col_q, ts_col_d;
  logic [15:0]    len_q, len_d;
  logic [NumKw-1:0] mask_q, mask_d;
  logic [23:0]    cnt_q, cnt_d;
  logic [23:0]    cap_q;

  logic           take;
  logic [1:0]     n_v;
  out_item_t      r0, r1, rr;
  logic [7:0]     c;
  logic           a_fail, a_emit;
  logic [3:0]     a_code;
  logic [4:0]     a_kind;
  logic [15:0]    a_len;
  after_e         a_next;
  logic           go_disp, go_eof;
  logic           b_emit, b_fail;
  logic [4:0]     b_kind;
  logic [15:0]    len_inc;
  logic [4:0]     id_kind;

  function automatic logic [PB-1:0] sat(logic [PB-1:0] v);
    return (v == '1) ? v : v + PB'(1);
  endfunction

  function automatic logic [23:0] p24(logic [PB-1:0] v);
    logic [31:0] w;
    w = 32'(v);
    return w[23:0];
  endfunction

  function automatic out_item_t mk(logic [4:0] kind, logic [PB-1:0] off,
                                   logic [PB-1:0] ln, logic [PB-1:0] col,
                                   logic [15:0] len, logic [3:0] err);
    out_item_t o;
    o.token_kind    = kind;
    o.start_offset  = p24(off);
    o.line_number   = p24(ln);
    o.column_number = p24(col);
    o.token_length  = len;
    o.error_code    = err;
    o.last_result   = 1'b0;
    return o;
  endfunction

  assign take      = cls_valid_i && room_i;
  assign cls_pop_o = take;
  assign c         = cls_i.char_byte;
  assign len_inc   = (len_q == LEN_MAX) ? len_q : len_q + 16'd1;

  // First keyword still alive whose length matches, else a plain identifier.
  always_comb begin
    id_kind = KIND_IDENT;
    for (int k = NumKw - 1; k >= 0; k--) begin
      if (mask_q[k] && ({11'd0, KW_LEN[k]} == len_q)) begin
        id_kind = KIND_KW0 + 5'(k);
      end
    end
  end

  always_comb begin
    mode_d     = mode_q;
    pend_d     = pend_q;
    off_d      = off_q;
    line_d     = line_q;
    col_d      = col_q;
    after_cr_d = after_cr_q;
    ts_off_d   = ts_off_q;
    ts_line_d  = ts_line_q;
    ts_col_d   = ts_col_q;
    len_d      = len_q;
    mask_d     = mask_q;
    cnt_d      = cnt_q;
    n_v        = 2'd0;
    r0         = '0;
    r1         = '0;
    rr         = '0;
    a_fail     = 1'b0;
    a_emit     = 1'b0;
    a_code     = ERR_NONE;
    a_kind     = KIND_EOF;
    a_len      = '0;
    a_next     = AF_NONE;
    go_disp    = 1'b0;
    go_eof     = 1'b0;
    b_emit     = 1'b0;
    b_fail     = 1'b0;
    b_kind     = KIND_EOF;

    if (take && mode_q != LX_DONE) begin
      if (cls_i.end_of_source) begin
        // Close whatever is open, then the EOF token unless closing it is an error.
        unique case (mode_q)
          LX_SLASH: begin
            a_fail = 1'b1;
            a_code = ERR_BAD_CHAR;
          end
          LX_BLOCK, LX_BLOCK_STAR: begin
            a_fail = 1'b1;
            a_code = ERR_OPEN_COMMENT;
          end
          LX_STRING: begin
            a_fail = 1'b1;
            a_code = ERR_OPEN_STRING;
          end
          LX_STRING_ESC: begin
            a_fail = 1'b1;
            a_code = ERR_BAD_ESCAPE;
          end
          LX_IDENT: begin
            a_emit = 1'b1;
            a_kind = id_kind;
            a_len  = len_q;
            a_next = AF_EOF;
          end
          LX_NUMBER: begin
            a_emit = 1'b1;
            a_kind = KIND_INT;
            a_len  = len_q;
            a_next = AF_EOF;
          end
          LX_OP: begin
            if (pend_q == "!") begin
              a_fail = 1'b1;
              a_code = ERR_BAD_CHAR;
            end else begin
              a_emit = 1'b1;
              a_kind = (pend_q == "=") ? KIND_ASSIGN :
                       (pend_q == "<") ? KIND_LT : KIND_GT;
              a_len  = 16'd1;
              a_next = AF_EOF;
            end
          end
          default: go_eof = 1'b1;
        endcase
        mode_d = LX_DONE;
      end else if (after_cr_q && c == 8'h0A) begin
        after_cr_d = 1'b0;
        off_d      = sat(off_q);
      end else begin
        after_cr_d = 1'b0;
        unique case (mode_q)
          LX_SLASH: begin
            if (c == "/") begin
              mode_d = LX_LINE;
            end else if (c == "*") begin
              mode_d = LX_BLOCK;
            end else begin
              a_fail = 1'b1;
              a_code = ERR_BAD_CHAR;
            end
          end
          LX_LINE: begin
            if (c == 8'h0D || c == 8'h0A) begin
              mode_d = LX_IDLE;
            end
          end
          LX_BLOCK: begin
            if (c == "*") begin
              mode_d = LX_BLOCK_STAR;
            end
          end
          LX_BLOCK_STAR: begin
            if (c == "/") begin
              mode_d = LX_IDLE;
            end else if (c != "*") begin
              mode_d = LX_BLOCK;
            end
          end
          LX_IDENT: begin
            if (cls_i.is_alpha || cls_i.is_numeral) begin
              if (len_q >= IDENT_LIMIT) begin
                a_fail = 1'b1;
                a_code = ERR_LONG_IDENT;
              end else begin
                mask_d = mask_q & kw_keep(len_q, c);
                len_d  = len_q + 16'd1;
              end
            end else begin
              a_emit = 1'b1;
              a_kind = id_kind;
              a_len  = len_q;
              a_next = AF_DISPATCH;
            end
          end
          LX_NUMBER: begin
            if (cls_i.is_numeral) begin
              len_d = len_inc;
            end else if (cls_i.is_alpha) begin
              a_fail = 1'b1;
              a_code = ERR_BAD_INT;
            end else begin
              a_emit = 1'b1;
              a_kind = KIND_INT;
              a_len  = len_q;
              a_next = AF_DISPATCH;
            end
          end
          LX_STRING: begin
            len_d = len_inc;
            if (c == 8'h22) begin
              if (len_inc > STR_LIMIT) begin
                a_fail = 1'b1;
                a_code = ERR_LONG_STRING;
              end else begin
                a_emit = 1'b1;
                a_kind = KIND_STRING;
                a_len  = len_inc;
                a_next = AF_IDLE;
              end
            end else if (c == 8'h5C) begin
              mode_d = LX_STRING_ESC;
            end else if (c < 8'd32 || c > 8'd126) begin
              a_fail = 1'b1;
              a_code = ERR_NONPRINT;
            end
          end
          LX_STRING_ESC: begin
            len_d = len_inc;
            if (c == "n" || c == 8'h5C || c == 8'h22) begin
              mode_d = LX_STRING;
            end else begin
              a_fail = 1'b1;
              a_code = ERR_BAD_ESCAPE;
            end
          end
          LX_OP: begin
            if (c == "=") begin
              a_emit = 1'b1;
              a_kind = (pend_q == "=") ? KIND_EQ :
                       (pend_q == "!") ? KIND_NE :
                       (pend_q == "<") ? KIND_LE : KIND_GE;
              a_len  = 16'd2;
              a_next = AF_IDLE;
            end else if (pend_q == "!") begin
              a_fail = 1'b1;
              a_code = ERR_BAD_CHAR;
            end else begin
              a_emit = 1'b1;
              a_kind = (pend_q == "=") ? KIND_ASSIGN :
                       (pend_q == "<") ? KIND_LT : KIND_GT;
              a_len  = 16'd1;
              a_next = AF_DISPATCH;
            end
          end
          default: go_disp = 1'b1;
        endcase
        off_d = sat(off_q);
        if (c == 8'h0D || c == 8'h0A) begin
          line_d     = sat(line_q);
          col_d      = PB'(1);
          after_cr_d = (c == 8'h0D);
        end else begin
          col_d = sat(col_q);
        end
      end

      // Closing step: a failure or a token at the recorded start.
      if (a_fail) begin
        r0     = mk(KIND_EOF, ts_off_q, ts_line_q, ts_col_q, 16'd0, a_code);
        n_v    = 2'd1;
        mode_d = LX_DONE;
      end else if (a_emit) begin
        if (cnt_q < cap_q) begin
          r0    = mk(a_kind, ts_off_q, ts_line_q, ts_col_q, a_len, ERR_NONE);
          n_v   = 2'd1;
          cnt_d = cnt_q + 24'd1;
          case (a_next)
            AF_IDLE:     mode_d = LX_IDLE;
            AF_DISPATCH: go_disp = 1'b1;
            AF_EOF:      go_eof = 1'b1;
            default:     ;
          endcase
        end else begin
          r0     = mk(KIND_EOF, ts_off_q, ts_line_q, ts_col_q, 16'd0, ERR_TOKEN_LIMIT);
          n_v    = 2'd1;
          mode_d = LX_DONE;
        end
      end

      // Start of a new token on the current byte.
      if (go_disp) begin
        mode_d = LX_IDLE;
        if (!cls_i.is_space) begin
          ts_off_d  = off_q;
          ts_line_d = line_q;
          ts_col_d  = col_q;
          if (c == "/") begin
            mode_d = LX_SLASH;
          end else if (cls_i.is_alpha) begin
            mask_d = kw_keep(16'd0, c);
            len_d  = 16'd1;
            mode_d = LX_IDENT;
          end else if (cls_i.is_numeral) begin
            len_d  = 16'd1;
            mode_d = LX_NUMBER;
          end else if (c == 8'h22) begin
            len_d  = 16'd1;
            mode_d = LX_STRING;
          end else begin
            case (c) inside
              "=", "!", "<", ">": begin
                pend_d = c;
                mode_d = LX_OP;
              end
              "*": begin b_emit = 1'b1; b_kind = KIND_STAR;   end
              "(": begin b_emit = 1'b1; b_kind = KIND_LPAREN; end
              ")": begin b_emit = 1'b1; b_kind = KIND_RPAREN; end
              "{": begin b_emit = 1'b1; b_kind = KIND_LBRACE; end
              "}": begin b_emit = 1'b1; b_kind = KIND_RBRACE; end
              ";": begin b_emit = 1'b1; b_kind = KIND_SEMI;   end
              "-": begin b_emit = 1'b1; b_kind = KIND_MINUS;  end
              "+": begin b_emit = 1'b1; b_kind = KIND_PLUS;   end
              ",": begin b_emit = 1'b1; b_kind = KIND_COMMA;  end
              default: b_fail = 1'b1;
            endcase
          end
        end
      end

      // Second step at the current position: a one-byte token, a bad
      // character, or the EOF token.
      if (b_fail) begin
        rr     = mk(KIND_EOF, off_q, line_q, col_q, 16'd0, ERR_BAD_CHAR);
        mode_d = LX_DONE;
      end else if (b_emit || go_eof) begin
        if (cnt_d < cap_q) begin
          rr    = mk(go_eof ? KIND_EOF : b_kind, off_q, line_q, col_q,
                     go_eof ? 16'd0 : 16'd1, ERR_NONE);
          cnt_d = cnt_d + 24'd1;
        end else begin
          rr     = mk(KIND_EOF, off_q, line_q, col_q, 16'd0, ERR_TOKEN_LIMIT);
          mode_d = LX_DONE;
        end
      end
      if (b_fail || b_emit || go_eof) begin
        if (n_v == 2'd0) begin
          r0 = rr;
        end else begin
          r1 = rr;
        end
        n_v = n_v + 2'd1;
      end

      if (n_v == 2'd1) begin
        r0.last_result = 1'b1;
      end else if (n_v == 2'd2) begin
        r1.last_result = 1'b1;
      end
    end
  end

  assign res0_we_o = (n_v != 2'd0);
  assign res1_we_o = (n_v == 2'd2);
  assign res0_o    = r0;
  assign res1_o    = r1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= LX_IDLE;
      pend_q     <= '0;
      off_q      <= '0;
      line_q     <= PB'(1);
      col_q      <= PB'(1);
      after_cr_q <= 1'b0;
      ts_off_q   <= '0;
      ts_line_q  <= PB'(1);
      ts_col_q   <= PB'(1);
      len_q      <= '0;
      mask_q     <= '1;
      cnt_q      <= '0;
      cap_q      <= CAP_RESET;
    end else begin
      mode_q     <= mode_d;
      pend_q     <= pend_d;
      off_q      <= off_d;
      line_q     <= line_d;
      col_q      <= col_d;
      after_cr_q <= after_cr_d;
      ts_off_q   <= ts_off_d;
      ts_line_q  <= ts_line_d;
      ts_col_q   <= ts_col_d;
      len_q      <= len_d;
      mask_q     <= mask_d;
      cnt_q      <= cnt_d;
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_done_sticks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mode_q == LX_DONE |=> mode_q == LX_DONE) else $error("left done mode");
  a_pair_starts_with_token: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res1_we_o |-> (res0_o.error_code == ERR_NONE && res0_we_o))
    else $error("error followed by another result");
  a_error_ends_stream: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res0_we_o && res0_o.error_code != ERR_NONE) |=> mode_q == LX_DONE)
    else $error("error without stop");
  a_no_results_when_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mode_q == LX_DONE |-> !res0_we_o) else $error("result after done");
`endif
endmodule

>>> hw/rtl/source_tokenizer.sv
// Streaming source tokenizer: one source byte (or the end marker) per item.
// Result path: an item waits in the front queue, is lexed at its head when the
// result queue has room for a pair, and its results go into the result queue.
// Throughput: one item per cycle while that room is there, set by the single step
// lexer in the back part; an item that yields two results drains at one pop each.
// Reset: asynchronous, active low; clears both queues, the lexer state and
// sets the token capacity to 4096.
module source_tokenizer #(
  parameter int MAX_IDENT_BYTES  = stok_pkg::MaxIdentBytes,
  parameter int MAX_STRING_BYTES = stok_pkg::MaxStringBytes,
  parameter int POSITION_BITS    = stok_pkg::PositionBits,
  parameter int QUEUE_DEPTH      = stok_pkg::QueueDepth
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [23:0]         cfg_wdata_i,
  input  logic                push,
  output logic                full,
  input  stok_pkg::in_item_t  in_item_i,
  output logic                empty,
  input  logic                pop,
  output stok_pkg::out_item_t out_item_o
);
  import stok_pkg::*;

  // Front part: classifies each byte and queues it for the lexer.
  cls_item_t cls;
  logic      cls_empty;
  logic      cls_pop;

  // Back part output: up to two results per item.
  logic      res0_we, res1_we;
  out_item_t res0, res1;
  logic [$clog2(QUEUE_DEPTH):0] out_free;
  logic      room;

  stok_front #(.DEPTH(QUEUE_DEPTH)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .item_i      (in_item_i),
    .cls_o       (cls),
    .cls_empty_o (cls_empty),
    .cls_pop_i   (cls_pop)
  );

  // The lexer only steps when the result queue can take a full pair, so an
  // item is never split across a stall.
  assign room = (out_free >= ($clog2(QUEUE_DEPTH) + 1)'(2));

  stok_back #(
    .MAX_IDENT_BYTES  (MAX_IDENT_BYTES),
    .MAX_STRING_BYTES (MAX_STRING_BYTES),
    .POSITION_BITS    (POSITION_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cls_i       (cls),
    .cls_valid_i (!cls_empty),
    .cls_pop_o   (cls_pop),
    .room_i      (room),
    .res0_we_o   (res0_we),
    .res0_o      (res0),
    .res1_we_o   (res1_we),
    .res1_o      (res1)
  );

  // Result queue: the oldest result sits on the ports while empty is low.
  stok_fifo #(.WIDTH($bits(out_item_t)), .DEPTH(QUEUE_DEPTH)) u_out_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we0_i   (res0_we),
    .wd0_i   (res0),
    .we1_i   (res1_we),
    .wd1_i   (res1),
    .re_i    (pop && !empty),
    .rd_o    (out_item_o),
    .empty_o (empty),
    .free_o  (out_free)
  );
endmodule

>>> tb/source_tokenizer_check.sv
module source_tokenizer_check (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [23:0]         cfg_wdata_i,
  input  logic                push,
  input  logic                full,
  input  stok_pkg::in_item_t  in_item_i,
  input  logic                empty,
  input  logic                pop,
  input  stok_pkg::out_item_t out_item_i,
  output int                  fail_count_o,
  output int                  outstanding_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import stok_pkg::*;

  localparam logic [7:0] CH_LF = 8'h0A;
  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [23:0] POS_MAX = 24'hFFFFFF;

  lex_mode_e   mode;
  logic [7:0]  pend_op;
  logic [23:0] cur_off, cur_ln, cur_col;
  logic [23:0] tok_off, tok_ln, tok_col;
  logic [23:0] tok_count, capacity;
  logic [7:0]  kw_mask;
  int unsigned tok_len;
  bit          saw_cr;
  out_item_t   step_res [2];
  int          step_n;
  out_item_t   expected_tokens [$];

  function automatic logic [23:0] sat_pos(logic [23:0] v);
    return (v == POS_MAX) ? v : v + 24'd1;
  endfunction

  function automatic bit is_letter(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
  endfunction

  function automatic bit is_num(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic void put_result(logic [4:0] kind, logic [23:0] o, logic [23:0] l,
                                     logic [23:0] cl, int unsigned len, logic [3:0] err);
    if (step_n < 2) begin
      step_res[step_n] = '{kind, o, l, cl, len[15:0], err, 1'b0};
      step_n++;
    end
  endfunction

  function automatic void fail_at(logic [3:0] err, logic [23:0] o, logic [23:0] l,
                                  logic [23:0] cl);
    put_result(KIND_EOF, o, l, cl, 0, err);
    mode = LX_DONE;
  endfunction

  function automatic void fail_token(logic [3:0] err);
    fail_at(err, tok_off, tok_ln, tok_col);
  endfunction

  // A token counts against the capacity; past it the token becomes an error.
  function automatic bit emit_at(logic [4:0] kind, logic [23:0] o, logic [23:0] l,
                                 logic [23:0] cl, int unsigned len);
    if (tok_count >= capacity) begin
      fail_at(ERR_TOKEN_LIMIT, o, l, cl);
      return 1'b0;
    end
    put_result(kind, o, l, cl, len, ERR_NONE);
    tok_count++;
    return 1'b1;
  endfunction

  function automatic bit emit_token(logic [4:0] kind, int unsigned len);
    return emit_at(kind, tok_off, tok_ln, tok_col, len);
  endfunction

  function automatic void narrow_keywords(logic [7:0] c);
    for (int k = 0; k < NumKw; k++) begin
      if (!(tok_len < KW_LEN[k] && KW_TEXT[k][tok_len] == c)) kw_mask[k] = 1'b0;
    end
  endfunction

  function automatic logic [4:0] word_kind();
    for (int k = 0; k < NumKw; k++) begin
      if (kw_mask[k] && KW_LEN[k] == tok_len) return KIND_KW0 + 5'(k);
    end
    return KIND_IDENT;
  endfunction

  // Operator alone, when the lookahead byte is not an equals sign.
  function automatic logic [4:0] lone_op(logic [7:0] c);
    case (c)
      "=": return KIND_ASSIGN;
      "<": return KIND_LT;
      ">": return KIND_GT;
      default: return KIND_EOF;
    endcase
  endfunction

  function automatic logic [4:0] pair_op(logic [7:0] c);
    case (c)
      "=": return KIND_EQ;
      "!": return KIND_NE;
      "<": return KIND_LE;
      default: return KIND_GE;
    endcase
  endfunction

  function automatic void start_token(logic [7:0] c);
    logic [4:0] kind;
    mode = LX_IDLE;
    if (c == " " || c == 8'h09 || c == CH_LF || c == CH_CR || c == 8'h0B || c == 8'h0C)
      return;
    tok_off = cur_off;
    tok_ln = cur_ln;
    tok_col = cur_col;
    if (c == "/") begin
      mode = LX_SLASH;
      return;
    end
    if (is_letter(c)) begin
      kw_mask = 8'hFF;
      tok_len = 0;
      narrow_keywords(c);
      tok_len = 1;
      mode = LX_IDENT;
      return;
    end
    if (is_num(c)) begin
      tok_len = 1;
      mode = LX_NUMBER;
      return;
    end
    if (c == "\"") begin
      tok_len = 1;
      mode = LX_STRING;
      return;
    end
    if (c == "=" || c == "!" || c == "<" || c == ">") begin
      pend_op = c;
      mode = LX_OP;
      return;
    end
    case (c)
      "*": kind = KIND_STAR;
      "(": kind = KIND_LPAREN;
      ")": kind = KIND_RPAREN;
      "{": kind = KIND_LBRACE;
      "}": kind = KIND_RBRACE;
      ";": kind = KIND_SEMI;
      "-": kind = KIND_MINUS;
      "+": kind = KIND_PLUS;
      ",": kind = KIND_COMMA;
      default: begin
        fail_token(ERR_BAD_CHAR);
        return;
      end
    endcase
    void'(emit_token(kind, 1));
  endfunction

  function automatic void take_byte(logic [7:0] c);
    case (mode)
      LX_SLASH: begin
        if (c == "/") mode = LX_LINE;
        else if (c == "*") mode = LX_BLOCK;
        else fail_token(ERR_BAD_CHAR);
      end
      LX_LINE: if (c == CH_CR || c == CH_LF) mode = LX_IDLE;
      LX_BLOCK: if (c == "*") mode = LX_BLOCK_STAR;
      LX_BLOCK_STAR: begin
        if (c == "/") mode = LX_IDLE;
        else if (c != "*") mode = LX_BLOCK;
      end
      LX_IDENT: begin
        if (is_letter(c) || is_num(c)) begin
          if (tok_len >= MaxIdentBytes) fail_token(ERR_LONG_IDENT);
          else begin
            narrow_keywords(c);
            tok_len++;
          end
        end else if (emit_token(word_kind(), tok_len)) start_token(c);
      end
      LX_NUMBER: begin
        if (is_num(c)) tok_len = (tok_len < 65535) ? tok_len + 1 : tok_len;
        else if (is_letter(c)) fail_token(ERR_BAD_INT);
        else if (emit_token(KIND_INT, tok_len)) start_token(c);
      end
      LX_STRING: begin
        tok_len = (tok_len < 65535) ? tok_len + 1 : tok_len;
        if (c == "\"") begin
          if (tok_len > MaxStringBytes * 2 + 2) fail_token(ERR_LONG_STRING);
          else if (emit_token(KIND_STRING, tok_len)) mode = LX_IDLE;
        end else if (c == "\\") mode = LX_STRING_ESC;
        else if (c < 8'd32 || c > 8'd126) fail_token(ERR_NONPRINT);
      end
      LX_STRING_ESC: begin
        tok_len = (tok_len < 65535) ? tok_len + 1 : tok_len;
        if (c == "n" || c == "\\" || c == "\"") mode = LX_STRING;
        else fail_token(ERR_BAD_ESCAPE);
      end
      LX_OP: begin
        if (c == "=") begin
          if (emit_token(pair_op(pend_op), 2)) mode = LX_IDLE;
        end else if (pend_op == "!") fail_token(ERR_BAD_CHAR);
        else if (emit_token(lone_op(pend_op), 1)) start_token(c);
      end
      default: start_token(c);
    endcase
  endfunction

  function automatic void take_end();
    bit ok;
    ok = 1'b1;
    case (mode)
      LX_SLASH: begin fail_token(ERR_BAD_CHAR); return; end
      LX_BLOCK, LX_BLOCK_STAR: begin fail_token(ERR_OPEN_COMMENT); return; end
      LX_STRING: begin fail_token(ERR_OPEN_STRING); return; end
      LX_STRING_ESC: begin fail_token(ERR_BAD_ESCAPE); return; end
      LX_IDENT: ok = emit_token(word_kind(), tok_len);
      LX_NUMBER: ok = emit_token(KIND_INT, tok_len);
      LX_OP: begin
        if (pend_op == "!") begin
          fail_token(ERR_BAD_CHAR);
          return;
        end
        ok = emit_token(lone_op(pend_op), 1);
      end
      default: ;
    endcase
    if (ok) void'(emit_at(KIND_EOF, cur_off, cur_ln, cur_col, 0));
    mode = LX_DONE;
  endfunction

  function automatic void predict_item(in_item_t it);
    step_n = 0;
    if (mode == LX_DONE) return;
    if (it.end_of_source) take_end();
    else if (saw_cr && it.char_byte == CH_LF) begin
      saw_cr = 1'b0;
      cur_off = sat_pos(cur_off);
    end else begin
      saw_cr = 1'b0;
      take_byte(it.char_byte);
      cur_off = sat_pos(cur_off);
      if (it.char_byte == CH_CR || it.char_byte == CH_LF) begin
        cur_ln = sat_pos(cur_ln);
        cur_col = 24'd1;
        saw_cr = (it.char_byte == CH_CR);
      end else cur_col = sat_pos(cur_col);
    end
    if (step_n > 0) step_res[step_n-1].last_result = 1'b1;
    for (int i = 0; i < step_n; i++) expected_tokens.push_back(step_res[i]);
  endfunction

  task automatic report(string msg);
    $display("%0t ns: ERROR %s", $realtime, msg);
    fail_count_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t want;
    if (!rst_ni) begin
      mode = LX_IDLE;
      pend_op = '0;
      cur_off = '0;
      cur_ln = 24'd1;
      cur_col = 24'd1;
      saw_cr = 1'b0;
      tok_off = '0;
      tok_ln = 24'd1;
      tok_col = 24'd1;
      tok_len = 0;
      kw_mask = 8'hFF;
      tok_count = '0;
      capacity = CAP_RESET;
      expected_tokens.delete();
      fail_count_o = 0;
      outstanding_o = 0;
    end else begin
      if (pop && !empty) begin
        if (expected_tokens.size() == 0) begin
          report($sformatf("result with nothing expected: %p", out_item_i));
        end else begin
          want = expected_tokens.pop_front();
          if (out_item_i.token_kind !== want.token_kind ||
              out_item_i.start_offset !== want.start_offset ||
              out_item_i.line_number !== want.line_number ||
              out_item_i.column_number !== want.column_number ||
              out_item_i.token_length !== want.token_length ||
              out_item_i.error_code !== want.error_code ||
              out_item_i.last_result !== want.last_result)
            report($sformatf("got %p, want %p", out_item_i, want));
        end
      end
      if (cfg_we_i) capacity = cfg_wdata_i;
      if (push && !full) predict_item(in_item_i);
      outstanding_o = expected_tokens.size();
    end
  end
endmodule

>>> tb/source_tokenizer_test.sv
module source_tokenizer_test;
  timeunit 1ns;
  timeprecision 1ps;
  import stok_pkg::*;

  localparam int CycleLimit = 400000;
  localparam int ItemsPerPhase = 550;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [23:0] cfg_wdata = '0;
  logic push = 1'b0;
  logic full;
  in_item_t in_item = '0;
  logic empty;
  logic pop = 1'b0;
  out_item_t out_item;
  int fail_count;
  int outstanding;
  int cycles = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  // Source text waiting to be sent, and whether the last thing built was a
  // word or number that a following word would merge with.
  logic [7:0] source_text [$];
  bit after_word;

  always #6 clk = ~clk;

  source_tokenizer DUT (
    .clk_i(clk), .rst_ni(rst_n), .cfg_we_i(cfg_we), .cfg_wdata_i(cfg_wdata),
    .push(push), .full(full), .in_item_i(in_item),
    .empty(empty), .pop(pop), .out_item_o(out_item)
  );

  source_tokenizer_check checker_i (
    .clk_i(clk), .rst_ni(rst_n), .cfg_we_i(cfg_we), .cfg_wdata_i(cfg_wdata),
    .push(push), .full(full), .in_item_i(in_item),
    .empty(empty), .pop(pop), .out_item_i(out_item),
    .fail_count_o(fail_count), .outstanding_o(outstanding)
  );

  // The result side stalls at random, one decision per cycle.
  always @(negedge clk) begin
    pop = ($urandom_range(99) >= recv_idle_pct);
  end

  // A run that hangs is caught here rather than left to spin forever.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("source_tokenizer: mismatch");
      $finish;
    end
  end

  // Offers one item and holds it until the block takes it. The sender may
  // first sit idle with push low. Push stays high afterwards, so back to back
  // items never lower and raise it within one time step.
  task automatic send_item(logic [7:0] b, bit eos);
    while ($urandom_range(99) < send_idle_pct) begin
      push = 1'b0;
      @(negedge clk);
    end
    push = 1'b1;
    in_item = '{char_byte: b, end_of_source: eos};
    do @(posedge clk); while (full);
    @(negedge clk);
  endtask

  task automatic send_text();
    while (source_text.size() > 0) send_item(source_text.pop_front(), 1'b0);
    push = 1'b0;
  endtask

  // Capacity is only rewritten once every expected result is out and the
  // pipeline has had time to settle, since whitespace and comments produce
  // no result that could be waited for.
  task automatic write_capacity(logic [23:0] cap);
    while (outstanding != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    cfg_we = 1'b1;
    cfg_wdata = cap;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic add_string(string s);
    for (int i = 0; i < s.len(); i++) source_text.push_back(s[i]);
  endtask

  function automatic logic [7:0] pick_letter();
    int r;
    r = $urandom_range(52);
    if (r < 26) return 8'("a" + r);
    if (r < 52) return 8'("A" + r - 26);
    return "_";
  endfunction

  function automatic logic [7:0] pick_alnum();
    return ($urandom_range(3) == 0) ? 8'("0" + $urandom_range(9)) : pick_letter();
  endfunction

  // Builds one well formed construct with random content. Errors end the
  // whole source, so random text never contains one; comments carry the
  // arbitrary bytes instead.
  task automatic add_construct();
    int r, n, k;
    logic [7:0] b;
    string ops [16] = '{"*", "(", ")", "{", "}", ";", "-", "+", ",",
                        "=", "<", ">", "==", "!=", "<=", ">="};
    r = $urandom_range(99);
    if (r < 30) begin
      if (after_word) source_text.push_back(" ");
      n = $urandom_range(9);
      if (n < 3) begin
        // Keyword, sometimes cut short or run on, to exercise the mask.
        k = $urandom_range(NumKw - 1);
        n = KW_LEN[k];
        if ($urandom_range(3) == 0) n = $urandom_range(1, n);
        for (int i = 0; i < n; i++) source_text.push_back(KW_TEXT[k][i]);
        if ($urandom_range(3) == 0) source_text.push_back(pick_alnum());
      end else begin
        n = ($urandom_range(19) == 0) ? MaxIdentBytes : $urandom_range(1, 12);
        source_text.push_back(pick_letter());
        for (int i = 1; i < n; i++) source_text.push_back(pick_alnum());
      end
      after_word = 1'b1;
    end else if (r < 42) begin
      if (after_word) source_text.push_back(" ");
      n = $urandom_range(1, 10);
      for (int i = 0; i < n; i++) source_text.push_back(8'("0" + $urandom_range(9)));
      after_word = 1'b1;
    end else begin
      if (r < 52) begin
        source_text.push_back("\"");
        n = $urandom_range(12);
        for (int i = 0; i < n; i++) begin
          if ($urandom_range(5) == 0) begin
            source_text.push_back("\\");
            k = $urandom_range(2);
            source_text.push_back(k == 0 ? "n" : (k == 1 ? "\\" : "\""));
          end else begin
            do b = 8'($urandom_range(32, 126)); while (b == "\"" || b == "\\");
            source_text.push_back(b);
          end
        end
        source_text.push_back("\"");
      end else if (r < 75) begin
        add_string(ops[$urandom_range(15)]);
      end else if (r < 85) begin
        n = $urandom_range(12);
        if ($urandom_range(1) == 0) begin
          add_string("//");
          for (int i = 0; i < n; i++) begin
            do b = 8'($urandom_range(255)); while (b == 8'h0A || b == 8'h0D);
            source_text.push_back(b);
          end
          if ($urandom_range(1) == 0) source_text.push_back(8'h0D);
          source_text.push_back(8'h0A);
        end else begin
          add_string("/*");
          for (int i = 0; i < n; i++) begin
            do b = 8'($urandom_range(255)); while (b == "*");
            source_text.push_back(b);
          end
          add_string($urandom_range(1) ? "*/" : "**/");
        end
      end else begin
        n = $urandom_range(1, 3);
        for (int i = 0; i < n; i++) begin
          case ($urandom_range(6))
            0: source_text.push_back(8'h09);
            1: source_text.push_back(8'h0A);
            2: source_text.push_back(8'h0D);
            3: source_text.push_back(8'h0B);
            4: source_text.push_back(8'h0C);
            5: begin source_text.push_back(8'h0D); source_text.push_back(8'h0A); end
            default: source_text.push_back(" ");
          endcase
        end
      end
      after_word = 1'b0;
    end
  endtask

  task automatic run_phase(int s_idle, int r_idle);
    int sent;
    send_idle_pct = s_idle;
    recv_idle_pct = r_idle;
    sent = 0;
    while (sent < ItemsPerPhase) begin
      add_construct();
      sent += source_text.size();
      send_text();
    end
  endtask

  initial begin
    repeat (2) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // The largest capacity first, so nothing trips the limit early.
    write_capacity(24'hFFFFFF);

    // Short directed source: operators with and without their equals sign,
    // a string holding every escape, a number and a word butting into them.
    send_idle_pct = 30;
    recv_idle_pct = 88;
    after_word = 1'b0;
    add_string("a1<=90;\"q\\\"\\\\\\n\"!=(*)>=<>");
    source_text.push_back(8'h0D);
    source_text.push_back(8'h0A);
    send_text();

    run_phase(30, 88);
    write_capacity(CAP_RESET);
    run_phase(88, 30);
    write_capacity(24'd3000);
    run_phase(0, 0);

    // Smallest capacity last: the next token must fail on the token limit,
    // and the end marker after it is dropped.
    write_capacity(24'd1);
    add_string(" zz ");
    send_text();
    send_item(8'hFF, 1'b1);
    push = 1'b0;

    while (outstanding != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (fail_count == 0) begin
      $display("source_tokenizer: match");
    end else begin
      $display("source_tokenizer: mismatch");
    end
    $finish;
  end
endmodule

>>> files.f
hw/rtl/stok_pkg.sv
hw/rtl/stok_fifo.sv
hw/rtl/stok_front.sv
hw/rtl/stok_back.sv
hw/rtl/source_tokenizer.sv
tb/source_tokenizer_check.sv
tb/source_tokenizer_test.sv
